// ----- rtl/htfd_pkg.sv -----
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types and constants for the humidity/temperature frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFS_W   = 12;
    localparam int unsigned RAW_W    = 16;
    localparam int unsigned TEMP_W   = 15;
    localparam int unsigned HUM_W    = 14;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // scale factors: 175.00 degC and 100.00 %RH in hundredths
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic signed [15:0] TEMP_BASE = 16'sd4500;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUM_CRC  = 2'd2
    } t_status;

    // position of the next byte in the frame
    typedef enum logic [5:0] {
        S_T_HI  = 6'b000001,
        S_T_LO  = 6'b000010,
        S_T_CRC = 6'b000100,
        S_H_HI  = 6'b001000,
        S_H_LO  = 6'b010000,
        S_H_CRC = 6'b100000
    } t_frame_state;

endpackage

`default_nettype wire

// ----- rtl/htfd_crc8.sv -----
// ----------------------------------------------------------------------------
// htfd_crc8
// One byte of CRC-8, polynomial 0x31, MSB first, unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_crc8 import htfd_pkg::*; (
    input  wire logic [BYTE_W-1:0] i_crc,
    input  wire logic [BYTE_W-1:0] i_data,
    output logic      [BYTE_W-1:0] o_crc
);

    always_comb begin
        logic [BYTE_W-1:0] c;
        c = i_crc ^ i_data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

// ----- rtl/humidity_temperature_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder
// CRC-checked decode of a six-byte humidity/temperature sensor readout.
// ----------------------------------------------------------------------------
// Takes one byte per cycle: temp hi, temp lo, temp CRC, hum hi, hum lo,
// hum CRC. Every byte is absorbed in the cycle it is accepted; the result
// for a frame appears in the output register on the cycle after its sixth
// byte. Scaling multiplies run early (temperature on the temp CRC byte,
// humidity on the hum CRC byte) so each cycle holds at most one multiply.
// o_in_stall rises only when the sixth byte is offered while a previous
// result is still held by a stalled consumer; every other byte is taken
// regardless. temp_offset is written through the cfg port (always ready)
// and is applied when the sixth byte arrives.
`default_nettype none

module humidity_temperature_frame_decoder import htfd_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // byte stream
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [BYTE_W-1:0]        i_rx_byte,
    input  wire logic                     i_frame_start,
    // result
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [TEMP_W-1:0]      o_temperature_centi,
    output logic [HUM_W-1:0]              o_humidity_centi,
    // configuration
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic signed [OFFS_W-1:0] i_cfg_temp_offset
);

    t_frame_state               r_state, n_state, w_pos;
    logic [BYTE_W-1:0]          r_crc, n_crc, w_crc_seed, w_crc_next;
    logic [RAW_W-1:0]           r_temp_raw, n_temp_raw;
    logic [RAW_W-1:0]           r_hum_raw, n_hum_raw;
    logic                       r_temp_ok, n_temp_ok;
    logic [TEMP_W-1:0]          r_temp_scaled, n_temp_scaled;
    logic signed [OFFS_W-1:0]   r_offset;
    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_status;
    logic signed [TEMP_W-1:0]   r_temp_out;
    logic [HUM_W-1:0]           r_hum_out;

    logic                       w_accept, w_final;
    logic [30:0]                w_temp_prod;
    logic [29:0]                w_hum_prod;
    logic signed [15:0]         w_temp_full;
    t_status                    w_status;

    assign o_cfg_ready = 1'b1;

    // position of the incoming byte; stray state codes restart the frame
    always_comb begin
        if (i_frame_start) begin
            w_pos = S_T_HI;
        end else begin
            unique case (r_state)
                S_T_HI, S_T_LO, S_T_CRC,
                S_H_HI, S_H_LO, S_H_CRC: w_pos = r_state;
                default:                 w_pos = S_T_HI;
            endcase
        end
    end

    assign w_final    = (w_pos == S_H_CRC);
    assign o_in_stall = r_out_valid && i_out_stall && w_final;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_crc_seed = (w_pos == S_T_HI || w_pos == S_H_HI) ? CRC_INIT : r_crc;

    htfd_crc8 u_crc (
        .i_crc  (w_crc_seed),
        .i_data (i_rx_byte),
        .o_crc  (w_crc_next)
    );

    assign w_temp_prod = 31'(r_temp_raw) * 31'(TEMP_SCALE);
    assign w_hum_prod  = 30'(r_hum_raw) * 30'(HUM_SCALE);

    // -45.00 degC base and user offset, 16-bit signed then trimmed
    assign w_temp_full = $signed({1'b0, r_temp_scaled}) - TEMP_BASE
                         - 16'(r_offset);

    always_comb begin
        if (!r_temp_ok) begin
            w_status = ST_TEMP_CRC;
        end else if (r_crc != i_rx_byte) begin
            w_status = ST_HUM_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_crc         = r_crc;
        n_temp_raw    = r_temp_raw;
        n_hum_raw     = r_hum_raw;
        n_temp_ok     = r_temp_ok;
        n_temp_scaled = r_temp_scaled;
        if (w_accept) begin
            unique case (w_pos)
                S_T_HI: begin
                    n_crc      = w_crc_next;
                    n_temp_raw = {i_rx_byte, BYTE_W'(0)};
                    n_state    = S_T_LO;
                end
                S_T_LO: begin
                    n_crc      = w_crc_next;
                    n_temp_raw = {r_temp_raw[RAW_W-1:BYTE_W], i_rx_byte};
                    n_state    = S_T_CRC;
                end
                S_T_CRC: begin
                    n_temp_ok     = (r_crc == i_rx_byte);
                    n_temp_scaled = w_temp_prod[30:16];
                    n_crc         = CRC_INIT;
                    n_state       = S_H_HI;
                end
                S_H_HI: begin
                    n_crc     = w_crc_next;
                    n_hum_raw = {i_rx_byte, BYTE_W'(0)};
                    n_state   = S_H_LO;
                end
                S_H_LO: begin
                    n_crc     = w_crc_next;
                    n_hum_raw = {r_hum_raw[RAW_W-1:BYTE_W], i_rx_byte};
                    n_state   = S_H_CRC;
                end
                S_H_CRC: begin
                    n_crc   = CRC_INIT;
                    n_state = S_T_HI;
                end
                default: begin
                    n_state = S_T_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_T_HI;
            r_crc      <= CRC_INIT;
            r_temp_raw <= '0;
            r_hum_raw  <= '0;
            r_temp_ok  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_crc      <= n_crc;
            r_temp_raw <= n_temp_raw;
            r_hum_raw  <= n_hum_raw;
            r_temp_ok  <= n_temp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp_scaled <= n_temp_scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_offset <= i_cfg_temp_offset;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_final) begin
            r_status <= w_status;
            if (w_status == ST_OK) begin
                r_temp_out <= w_temp_full[TEMP_W-1:0];
                r_hum_out  <= w_hum_prod[29:16];
            end else begin
                r_temp_out <= '0;
                r_hum_out  <= '0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_temperature_centi = r_temp_out;
    assign o_humidity_centi    = r_hum_out;

endmodule

`default_nettype wire

// ----- rtl/htfd_checker.sv -----
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level assertions for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_checker import htfd_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic [BYTE_W-1:0]        i_rx_byte,
    input wire logic                     i_frame_start,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [STATUS_W-1:0]      o_status,
    input wire logic signed [TEMP_W-1:0] o_temperature_centi,
    input wire logic [HUM_W-1:0]         o_humidity_centi,
    input wire logic                     i_cfg_valid,
    input wire logic                     o_cfg_ready,
    input wire logic signed [OFFS_W-1:0] i_cfg_temp_offset
);

    // held result does not move
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_temperature_centi) && $stable(o_humidity_centi))
        else $error("result changed while stalled");

    // a failed check carries zeroed readings
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_temperature_centi == '0 && o_humidity_centi == '0)
        else $error("nonzero reading on CRC failure");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_TEMP_CRC
            || o_status == ST_HUM_CRC)
        else $error("undefined status code");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |-> o_humidity_centi <= HUM_W'(10000))
        else $error("humidity above 100.00 percent");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind humidity_temperature_frame_decoder htfd_checker u_htfd_checker (.*);

`default_nettype wire
